// ----- rtl/multi_turn_motor_feedback_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multi-turn motor feedback decoder
// Checks use clk and rst of the including module and are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_TURN_MOTOR_FEEDBACK_DECODER_ASSERT_SVH
`define MULTI_TURN_MOTOR_FEEDBACK_DECODER_ASSERT_SVH

// Condition must hold at every rising clock edge.
`define MTMFD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MTMFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mtmfd_pkg.sv -----
// ----------------------------------------------------------------------------
// mtmfd_pkg
// Types and constants shared by the motor feedback decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtmfd_pkg;

  localparam int ID_W      = 11;
  localparam int RAW_W     = 16;
  localparam int TEMP_W    = 8;
  localparam int MOTOR_W   = 3;
  localparam int SCALE_W   = 32;
  localparam int VALUE_W   = 48;
  localparam int CFG_IDX_W = 2;

  localparam int S_DATA_W  = 56;   // 3 x 16 + 8, already whole bytes
  localparam int M_DATA_W  = 152;  // 3 x 48 + 8, already whole bytes

  localparam logic [ID_W-1:0] ID_FIRST = 11'h201;
  localparam logic [ID_W-1:0] ID_LAST  = 11'h208;

  localparam logic signed [SCALE_W-1:0] SCALE_RESET = 32'sh0100_0000;  // 1.0 in Q8.24

  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_SCALE  = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [MOTOR_W-1:0]       motor;
    logic [RAW_W-1:0]         raw_position;
    logic signed [RAW_W-1:0]  raw_velocity;
    logic signed [RAW_W-1:0]  raw_current;
    logic [TEMP_W-1:0]        temperature;
  } frame_item_t;

  typedef struct packed {
    logic a_valid;
    logic b_valid;
  } back_status_t;

endpackage

// ----- rtl/mtmfd_front.sv -----
// ----------------------------------------------------------------------------
// mtmfd_front
// Accepts feedback frames, filters identifiers and forms queue entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtmfd_front #(
  parameter int MOTOR_COUNT = 8
) (
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mtmfd_pkg::S_DATA_W-1:0] s_axis_tdata,
  input  logic [mtmfd_pkg::ID_W-1:0]    s_axis_tuser,
  input  logic                          q_full,
  output logic                          q_push,
  output mtmfd_pkg::frame_item_t        q_push_item
);
  import mtmfd_pkg::*;

  logic [ID_W-1:0] id_offset;
  logic            id_known;

  assign id_offset = s_axis_tuser - ID_FIRST;
  assign id_known  = (s_axis_tuser >= ID_FIRST) && (s_axis_tuser <= ID_LAST) &&
                     (id_offset < ID_W'(MOTOR_COUNT));

  // unknown frames are taken and dropped
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full && id_known;

  assign q_push_item.motor        = id_offset[MOTOR_W-1:0];
  assign q_push_item.raw_position = s_axis_tdata[15:0];
  assign q_push_item.raw_velocity = s_axis_tdata[31:16];
  assign q_push_item.raw_current  = s_axis_tdata[47:32];
  assign q_push_item.temperature  = s_axis_tdata[55:48];

endmodule

// ----- rtl/mtmfd_queue.sv -----
// ----------------------------------------------------------------------------
// mtmfd_queue
// Short FIFO between the frame front end and the decode pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtmfd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  mtmfd_pkg::frame_item_t push_item,
  output logic                   full,
  output logic                   q_valid,
  output mtmfd_pkg::frame_item_t q_item,
  input  logic                   pop
);
  import mtmfd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_item_t      entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];

endmodule

// ----- rtl/mtmfd_back.sv -----
// ----------------------------------------------------------------------------
// mtmfd_back
// Decode pipeline: position unwrap, scaling multipliers, saturating
// multi-turn accumulation and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtmfd_back #(
  parameter int MOTOR_COUNT      = 8,
  parameter int HALF_TURN_COUNTS = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mtmfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mtmfd_pkg::SCALE_W-1:0]     cfg_data,
  input  logic                              q_valid,
  input  mtmfd_pkg::frame_item_t            q_item,
  output logic                              q_pop,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mtmfd_pkg::M_DATA_W-1:0]    m_axis_tdata,
  output logic [mtmfd_pkg::MOTOR_W-1:0]     m_axis_tuser,
  output mtmfd_pkg::back_status_t           status
);
  import mtmfd_pkg::*;

  localparam logic signed [17:0] HALF_TURN = 18'(HALF_TURN_COUNTS);
  localparam logic signed [17:0] FULL_TURN = 18'(2 * HALF_TURN_COUNTS);
  localparam logic signed [49:0] SUM_MAX   = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] SUM_MIN   = 50'sh3_8000_0000_0000;

  logic signed [SCALE_W-1:0] position_scale;
  logic signed [SCALE_W-1:0] velocity_scale;
  logic signed [SCALE_W-1:0] current_scale;

  logic                      pending  [MOTOR_COUNT];
  logic [RAW_W-1:0]          last_pos [MOTOR_COUNT];
  logic signed [VALUE_W-1:0] acc      [MOTOR_COUNT];

  // stage A: unwrapped position step
  logic                      a_valid;
  logic [MOTOR_W-1:0]        a_motor;
  logic signed [16:0]        a_step;
  logic signed [RAW_W-1:0]   a_vel;
  logic signed [RAW_W-1:0]   a_cur;
  logic [TEMP_W-1:0]         a_temp;

  // stage B: products
  logic                      b_valid;
  logic [MOTOR_W-1:0]        b_motor;
  logic signed [48:0]        b_pos_step;
  logic signed [VALUE_W-1:0] b_vel;
  logic signed [VALUE_W-1:0] b_cur;
  logic [TEMP_W-1:0]         b_temp;

  logic o_ready, b_ready, a_ready;
  logic a_load, b_load, o_load;

  logic                      sel_pending;
  logic [RAW_W-1:0]          sel_last;
  logic signed [VALUE_W-1:0] sel_acc;
  logic [RAW_W-1:0]          diff;
  logic signed [17:0]        diff_ext;
  logic signed [17:0]        unwrapped;
  logic signed [16:0]        step_next;
  logic signed [49:0]        sum;
  logic signed [VALUE_W-1:0] sum_sat;

  // --------------------------------------------------------------------------
  // handshake chain
  assign o_ready = !m_axis_tvalid || m_axis_tready;
  assign b_ready = !b_valid || o_ready;
  assign a_ready = !a_valid || b_ready;
  assign q_pop   = q_valid && a_ready;
  assign a_load  = q_pop;
  assign b_load  = a_valid && b_ready;
  assign o_load  = b_valid && o_ready;

  assign status.a_valid = a_valid;
  assign status.b_valid = b_valid;

  // --------------------------------------------------------------------------
  // scale registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position_scale <= SCALE_RESET;
      velocity_scale <= SCALE_RESET;
      current_scale  <= SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_POSITION_SCALE: position_scale <= cfg_data;
        CFG_VELOCITY_SCALE: velocity_scale <= cfg_data;
        CFG_CURRENT_SCALE:  current_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // per-motor state selection
  always_comb begin
    sel_pending = 1'b0;
    sel_last    = '0;
    sel_acc     = '0;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      if (int'(q_item.motor) == i) begin
        sel_pending = pending[i];
        sel_last    = last_pos[i];
      end
      if (int'(b_motor) == i) begin
        sel_acc = acc[i];
      end
    end
  end

  // wrapping difference; exactly half a turn is left alone
  always_comb begin
    diff     = q_item.raw_position - sel_last;
    diff_ext = {{2{diff[RAW_W-1]}}, diff};
    if (diff_ext > HALF_TURN) begin
      unwrapped = diff_ext - FULL_TURN;
    end else if (diff_ext < -HALF_TURN) begin
      unwrapped = diff_ext + FULL_TURN;
    end else begin
      unwrapped = diff_ext;
    end
    step_next = sel_pending ? '0 : unwrapped[16:0];
  end

  // saturating accumulate
  always_comb begin
    sum = 50'(sel_acc) + 50'(b_pos_step);
    if (sum > SUM_MAX) begin
      sum_sat = SUM_MAX[VALUE_W-1:0];
    end else if (sum < SUM_MIN) begin
      sum_sat = SUM_MIN[VALUE_W-1:0];
    end else begin
      sum_sat = sum[VALUE_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // per-motor state update
  always_ff @(posedge clk) begin
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      if (rst) begin
        pending[i]  <= 1'b1;
        last_pos[i] <= '0;
        acc[i]      <= '0;
      end else begin
        if (a_load && int'(q_item.motor) == i) begin
          pending[i]  <= 1'b0;
          last_pos[i] <= q_item.raw_position;
        end
        if (o_load && int'(b_motor) == i) begin
          acc[i] <= sum_sat;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= q_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (o_ready) begin
        m_axis_tvalid <= b_valid;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_motor <= q_item.motor;
      a_step  <= step_next;
      a_vel   <= q_item.raw_velocity;
      a_cur   <= q_item.raw_current;
      a_temp  <= q_item.temperature;
    end
    if (b_load) begin
      b_motor    <= a_motor;
      b_pos_step <= a_step * position_scale;
      b_vel      <= a_vel * velocity_scale;
      b_cur      <= a_cur * current_scale;
      b_temp     <= a_temp;
    end
    if (o_load) begin
      m_axis_tuser <= b_motor;
      m_axis_tdata <= {b_temp, b_cur, b_vel, sum_sat};
    end
  end

endmodule

// ----- rtl/multi_turn_motor_feedback_decoder.sv -----
// ----------------------------------------------------------------------------
// multi_turn_motor_feedback_decoder
// Decodes motor feedback frames into multi-turn position, scaled velocity and
// current per motor.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tuser id, tdata raw fields
//   m_axis    out  tvalid/tready          tuser motor, tdata results
//   cfg       in   cfg_write              cfg_index, cfg_data
//
// Sustains one frame per clock while the output is not stalled; a taken frame
// passes the queue, unwrap stage, multiplier stage and result register.
// Frames with an unknown identifier are taken and give no result.
// Reset sets every scale to 1.0 and marks all motors as awaiting a first frame.
// A stalled output fills the pipeline and then the two-entry queue before
// s_axis_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "multi_turn_motor_feedback_decoder_assert.svh"

module multi_turn_motor_feedback_decoder #(
  parameter int MOTOR_COUNT      = 8,
  parameter int HALF_TURN_COUNTS = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mtmfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtmfd_pkg::SCALE_W-1:0]   cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // raw_position, raw_velocity, raw_current, temperature
  input  logic [mtmfd_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // frame_id
  input  logic [mtmfd_pkg::ID_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // position_total, velocity_value, current_value, temperature_out
  output logic [mtmfd_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // motor_index
  output logic [mtmfd_pkg::MOTOR_W-1:0]   m_axis_tuser
);
  import mtmfd_pkg::*;

  logic         q_full;
  logic         q_push;
  frame_item_t  q_push_item;
  logic         q_valid;
  frame_item_t  q_item;
  logic         q_pop;
  back_status_t bk_status;

  mtmfd_front #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_push_item   (q_push_item)
  );

  mtmfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (q_pop)
  );

  mtmfd_back #(
    .MOTOR_COUNT      (MOTOR_COUNT),
    .HALF_TURN_COUNTS (HALF_TURN_COUNTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .status        (bk_status)
  );

  `MTMFD_ASSERT_ALWAYS(a_motor_in_range, !m_axis_tvalid || (int'(m_axis_tuser) < MOTOR_COUNT), "result for a motor beyond MOTOR_COUNT")
  `MTMFD_ASSERT_NEXT(a_pop_fills_stage, q_pop, bk_status.a_valid, "queue pop did not reach the unwrap stage")
  `MTMFD_ASSERT_NEXT(a_result_retires, m_axis_tvalid && m_axis_tready && !bk_status.b_valid, !m_axis_tvalid, "taken result shown again")

endmodule

// ----- test/multi_turn_motor_feedback_decoder_checker.sv -----
// ----------------------------------------------------------------------------
// multi_turn_motor_feedback_decoder_checker
// Watches the config port and both stream channels of the decoder. Each
// frame taken on s_axis is decoded by a local model of the per-motor unwrap,
// scaling and saturating accumulation. Each m_axis transaction is compared
// field by field with the oldest decoded result still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_turn_motor_feedback_decoder_checker #(
  parameter int MOTOR_COUNT      = 8,
  parameter int HALF_TURN_COUNTS = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mtmfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtmfd_pkg::SCALE_W-1:0]   cfg_data,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [mtmfd_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input  logic [mtmfd_pkg::ID_W-1:0]      s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [mtmfd_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input  logic [mtmfd_pkg::MOTOR_W-1:0]   m_axis_tuser,
  output int                              failures,
  output int                              outstanding
);

  import mtmfd_pkg::*;

  typedef struct {
    logic [MOTOR_W-1:0] motor;
    logic [VALUE_W-1:0] position;
    logic [VALUE_W-1:0] velocity;
    logic [VALUE_W-1:0] current;
    logic [TEMP_W-1:0]  temperature;
  } feedback_result_t;

  localparam longint TOTAL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint TOTAL_MIN = -TOTAL_MAX - 1;

  longint           position_gain;
  longint           velocity_gain;
  longint           current_gain;
  logic             awaiting_first [MOTOR_COUNT];
  logic [RAW_W-1:0] prev_count     [MOTOR_COUNT];
  longint           turn_total     [MOTOR_COUNT];

  feedback_result_t expected_results[$];

  task automatic decode_feedback(input logic [ID_W-1:0] id, input logic [S_DATA_W-1:0] data);
    feedback_result_t        r;
    logic [RAW_W-1:0]        count;
    logic signed [RAW_W-1:0] speed;
    logic signed [RAW_W-1:0] amps;
    logic signed [RAW_W-1:0] wrap_diff;
    longint                  diff;
    longint                  step;
    longint                  sum;
    longint                  product;
    int                      m;
    count = data[15:0];
    speed = data[31:16];
    amps  = data[47:32];
    if (id < ID_FIRST || id > ID_LAST) return;
    m = int'(id - ID_FIRST);
    if (m >= MOTOR_COUNT) return;
    step = 0;
    if (awaiting_first[m]) begin
      awaiting_first[m] = 1'b0;
    end else begin
      wrap_diff = count - prev_count[m];
      diff = longint'(wrap_diff);
      // exactly half a turn is left alone
      if (diff > HALF_TURN_COUNTS) begin
        diff = diff - 2 * HALF_TURN_COUNTS;
      end else if (diff < -HALF_TURN_COUNTS) begin
        diff = diff + 2 * HALF_TURN_COUNTS;
      end
      step = diff * position_gain;
    end
    prev_count[m] = count;
    sum = turn_total[m] + step;
    if (sum > TOTAL_MAX) sum = TOTAL_MAX;
    else if (sum < TOTAL_MIN) sum = TOTAL_MIN;
    turn_total[m] = sum;
    r.motor       = m[MOTOR_W-1:0];
    r.position    = sum[VALUE_W-1:0];
    product       = longint'(speed) * velocity_gain;
    r.velocity    = product[VALUE_W-1:0];
    product       = longint'(amps) * current_gain;
    r.current     = product[VALUE_W-1:0];
    r.temperature = data[55:48];
    expected_results.push_back(r);
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      failures++;
    end
  endtask

  task automatic check_result();
    feedback_result_t r;
    if (expected_results.size() == 0) begin
      $error("unexpected result transaction: motor_index 0x%0h", m_axis_tuser);
      failures++;
      return;
    end
    r = expected_results.pop_front();
    compare_field("motor_index", 64'(r.motor), 64'(m_axis_tuser));
    compare_field("position_total", 64'(r.position), 64'(m_axis_tdata[47:0]));
    compare_field("velocity_value", 64'(r.velocity), 64'(m_axis_tdata[95:48]));
    compare_field("current_value", 64'(r.current), 64'(m_axis_tdata[143:96]));
    compare_field("temperature_out", 64'(r.temperature), 64'(m_axis_tdata[151:144]));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      position_gain = longint'(SCALE_RESET);
      velocity_gain = longint'(SCALE_RESET);
      current_gain  = longint'(SCALE_RESET);
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        awaiting_first[i] = 1'b1;
        prev_count[i]     = '0;
        turn_total[i]     = 0;
      end
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_POSITION_SCALE: position_gain = longint'($signed(cfg_data));
          CFG_VELOCITY_SCALE: velocity_gain = longint'($signed(cfg_data));
          CFG_CURRENT_SCALE:  current_gain  = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      // a result only leaves after its frame has passed the registered stages, so order here is free
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) decode_feedback(s_axis_tuser, s_axis_tdata);
    end
    outstanding = expected_results.size();
  end

endmodule

// ----- test/multi_turn_motor_feedback_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// multi_turn_motor_feedback_decoder_tb
// Drives feedback frames into the decoder: a directed set covering unknown
// ids, first frames, half-turn boundaries and field extremes, then phases of
// spinning motors under different scale settings, including saturation of
// the position accumulator. Both channels stall at random but in one phase. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_turn_motor_feedback_decoder_tb;

  import mtmfd_pkg::*;

  localparam int LIMIT       = 100000;
  localparam int SETTLE      = 8;
  localparam int PHASE_ITEMS = 76;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped, write is dropped

  logic                 clk;
  logic                 rst           = 1'b1;
  logic                 cfg_write     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [SCALE_W-1:0]   cfg_data      = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [ID_W-1:0]      s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_axis_tdata;
  logic [MOTOR_W-1:0]   m_axis_tuser;

  int   failures;
  int   outstanding;
  int   cycles = 0;
  logic steady = 1'b0;

  // stimulus-side view of where each motor's encoder sits
  logic [RAW_W-1:0] spin_count [8];
  logic             spin_up    [8];
  int               focus_motor;

  multi_turn_motor_feedback_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  multi_turn_motor_feedback_decoder_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .failures      (failures),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("multi_turn_motor_feedback_decoder_tb failed");
      $finish;
    end
  end

  task automatic send_frame(input logic [ID_W-1:0] id, input logic [RAW_W-1:0] pos, vel, cur,
                            input logic [TEMP_W-1:0] temp);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= id;
    s_axis_tdata  <= {temp, cur, vel, pos};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // hold the input, let every result drain, then allow for ignored frames
  task automatic pause_input();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_scale(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_scales(input logic [SCALE_W-1:0] p, v, c);
    write_scale(CFG_POSITION_SCALE, p);
    write_scale(CFG_VELOCITY_SCALE, v);
    write_scale(CFG_CURRENT_SCALE, c);
  endtask

  // mostly motors turning steadily; one motor spins hard to reach saturation
  task automatic spin_frame();
    int               pick;
    int               m;
    int               delta;
    logic [ID_W-1:0]  id;
    logic [RAW_W-1:0] pos;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      id  = ID_W'($urandom_range(0, 2047));
      pos = RAW_W'($urandom);
    end else begin
      m  = (pick < 55) ? focus_motor : int'($urandom_range(0, 7));
      id = ID_FIRST + ID_W'(m);
      if (m == focus_motor) begin
        pos = spin_count[m] + RAW_W'($urandom_range(3000, 4096));
      end else if ($urandom_range(0, 9) < 7) begin
        delta = $urandom_range(0, 4096);
        pos   = spin_up[m] ? spin_count[m] + RAW_W'(delta) : spin_count[m] - RAW_W'(delta);
      end else begin
        pos = RAW_W'($urandom);
      end
      spin_count[m] = pos;
    end
    send_frame(id, pos, RAW_W'($urandom), RAW_W'($urandom), TEMP_W'($urandom));
  endtask

  initial begin
    focus_motor = $urandom_range(0, 7);
    for (int i = 0; i < 8; i++) begin
      spin_count[i] = RAW_W'($urandom);
      spin_up[i]    = 1'($urandom_range(0, 1));
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: unknown ids, then half-turn edges on motor 0, then first frames
    send_frame(11'h000, 16'h0000, 16'h0000, 16'h0000, 8'h00);
    send_frame(11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_frame(ID_FIRST - ID_W'(1), 16'h1234, 16'h0001, 16'h0001, 8'h01);
    send_frame(ID_LAST + ID_W'(1), 16'h4321, 16'h0002, 16'h0002, 8'h02);
    send_frame(ID_FIRST, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF);
    send_frame(ID_FIRST, 16'h0FFF, 16'h8000, 16'h7FFF, 8'h00);
    send_frame(ID_FIRST, 16'h1FFF, 16'hFFFF, 16'h0000, 8'h80);
    send_frame(ID_FIRST, 16'h0FFE, 16'h0000, 16'hFFFF, 8'h7F);
    send_frame(ID_FIRST, 16'h1FFF, 16'h0001, 16'h8001, 8'h55);
    send_frame(ID_FIRST, 16'h0FFF, 16'h7FFE, 16'h0001, 8'hAA);
    send_frame(ID_FIRST, 16'h8FFF, 16'h5555, 16'hAAAA, 8'h0F);
    send_frame(ID_FIRST, 16'h0FFF, 16'hAAAA, 16'h5555, 8'hF0);
    for (int i = 1; i < 8; i++) begin
      send_frame(ID_FIRST + ID_W'(i), 16'(i * 16'h2345), 16'h8000, 16'h7FFF, 8'(i * 32));
    end
    send_frame(ID_LAST, 16'(7 * 16'h2345), 16'h0000, 16'h0000, 8'hFF);
    send_frame(ID_FIRST + ID_W'(4), 16'hFFFF, 16'h0000, 16'hFFFF, 8'h00);

    for (int p = 0; p < 5; p++) begin
      pause_input();
      case (p)
        0: set_scales(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        1: begin
          set_scales(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
          write_scale(CFG_SPARE, $urandom);
        end
        2: set_scales(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        3: set_scales($urandom, $urandom, $urandom);
        default: set_scales(SCALE_RESET, 32'hFFFF_FFFF, 32'h0000_0001);
      endcase
      steady = (p == 2);
      repeat (PHASE_ITEMS) spin_frame();
    end

    pause_input();
    if (failures == 0 && outstanding == 0) begin
      $display("multi_turn_motor_feedback_decoder_tb passed");
    end else begin
      $display("multi_turn_motor_feedback_decoder_tb failed");
    end
    $finish;
  end

endmodule

// ----- multi_turn_motor_feedback_decoder.f -----
+incdir+rtl
rtl/mtmfd_pkg.sv
rtl/mtmfd_front.sv
rtl/mtmfd_queue.sv
rtl/mtmfd_back.sv
rtl/multi_turn_motor_feedback_decoder.sv
test/multi_turn_motor_feedback_decoder_checker.sv
test/multi_turn_motor_feedback_decoder_tb.sv
